// ===== hdl/bdb_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bdb_pkg
// Shared types, codes and word layouts of the bounded deque/bag unit.
// ---------------------------------------------------------------------------
package bdb_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CONTAINS   = 3'd4,
    OP_REMOVE     = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  localparam int IN_PAD_W  = IN_TDATA_W - 3 - DATA_W;
  localparam int OUT_PAD_W = OUT_TDATA_W - 2 - 1 - 2 * DATA_W - COUNT_W - 1;

  // first member sits in the top bits
  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    logic [DATA_W-1:0]   value;
    logic [2:0]          opcode;
  } in_word_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic                 is_empty;
    logic [COUNT_W-1:0]   entry_count;
    logic [DATA_W-1:0]    back_value;
    logic [DATA_W-1:0]    front_value;
    logic                 found;
    status_t              status;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hdl/bounded_deque_bag_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bounded_deque_bag_unit
// Bounded ordered store of signed values, usable as a deque and as a bag.
// ---------------------------------------------------------------------------
// Entries live in a circular buffer in one RAM (registered read); head index,
// count and copies of the front and back values sit in flip-flops. One word
// is worked on at a time. A push is done in the execute state. A pop
// re-reads front and back from the RAM when entries remain. Contains
// scans through the RAM one entry a cycle. Remove scans, then moves each
// later entry one place towards the front, one a cycle, then re-reads front
// and back when entries remain; when nothing matches it reports not found.
// A finished result sits in an output register, so the next word is taken
// while it waits. Empty pops, searches and removes report an empty status;
// a push into a full store is dropped. Unused opcodes leave the store alone
// and report ok.
module bounded_deque_bag_unit #(
  parameter int DEPTH       = bdb_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bdb_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // opcode [2:0], value [34:3], zero pad [39:35]
  input  wire logic [bdb_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // status [1:0], found [2], front_value [34:3], back_value [66:35],
  // entry_count [71:67], is_empty [72], zero pad [79:73]
  output logic [bdb_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  import bdb_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_RD_FRONT,
    S_RD_BACK,
    S_RD_LAST,
    S_FINISH
  } state_t;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  // circular position -> RAM address
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(p);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  state_t    state_r,    state_nxt;
  opcode_t   op_r,       op_nxt;
  val_t      val_r,      val_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r,  occ_nxt;
  val_t      front_r,    front_nxt;
  val_t      back_r,     back_nxt;
  status_t   status_r,   status_nxt;
  logic      found_r,    found_nxt;
  logic [CW-1:0] pos_r,  pos_nxt;       // next position to read
  logic      pend_r,     pend_nxt;      // a read is in flight
  logic [CW-1:0] pend_pos_r, pend_pos_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  in_word_t  in_word;
  logic      out_load;
  logic      ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  val_t      ram_wdata;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic [CW-1:0] rd_pos;
  logic [IW-1:0] head_m1, head_p1, tail_slot;
  logic      is_full, is_empty, issue, match;

  assign in_word = in_tdata;

  bdb_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign is_full   = (occ_r == CW'(DEPTH));
  assign is_empty  = (occ_r == '0);
  assign head_m1   = (head_r == '0) ? IW'(DEPTH - 1) : head_r - IW'(1);
  assign head_p1   = slot_of(head_r, CW'(1));
  assign tail_slot = slot_of(head_r, occ_r);

  // read address: front/back refresh, else the scan/shift pointer
  always_comb begin
    case (state_r)
      S_RD_FRONT: rd_pos = '0;
      S_RD_BACK:  rd_pos = occ_r - CW'(1);
      default:    rd_pos = pos_r;
    endcase
  end
  assign ram_raddr = slot_of(head_r, rd_pos);

  assign match = pend_r && (val_t'(ram_rdata) == val_r);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    status_nxt   = status_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;
    pend_nxt     = pend_r;
    pend_pos_nxt = pend_pos_r;
    in_tready    = (state_r == S_IDLE);
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = tail_slot;
    ram_wdata    = val_r;
    issue        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = opcode_t'(in_word.opcode);
          val_nxt    = VALUE_WIDTH'($signed(in_word.value));
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_FINISH;
        case (op_r)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we  = 1'b1;
              occ_nxt = occ_r + CW'(1);
              if (op_r == OP_PUSH_FRONT) begin
                ram_waddr = head_m1;
                head_nxt  = head_m1;
                front_nxt = val_r;
                if (is_empty) begin
                  back_nxt = val_r;
                end
              end else begin
                back_nxt = val_r;
                if (is_empty) begin
                  front_nxt = val_r;
                end
              end
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              occ_nxt = occ_r - CW'(1);
              if (op_r == OP_POP_FRONT) begin
                head_nxt = head_p1;
              end
              if (occ_r != CW'(1)) begin
                state_nxt = S_RD_FRONT;
              end
            end
          end
          OP_CONTAINS, OP_REMOVE: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              pos_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          default: ;
        endcase
      end

      // one read issued per cycle, compared once the RAM data is registered
      S_SCAN: begin
        issue = (pos_r < occ_r) && !match;
        if (issue) begin
          pos_nxt      = pos_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_pos_nxt = pos_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (match) begin
          found_nxt = 1'b1;
          pend_nxt  = 1'b0;
          if (op_r == OP_REMOVE) begin
            pos_nxt   = pend_pos_r + CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (pend_r && (pend_pos_r == occ_r - CW'(1))) begin
          pend_nxt = 1'b0;
          if (op_r == OP_REMOVE) begin
            status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_FINISH;
        end
      end

      // read entry p, write it to p-1 when its read data returns
      S_SHIFT: begin
        issue = (pos_r < occ_r);
        if (issue) begin
          pos_nxt      = pos_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_pos_nxt = pos_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = slot_of(head_r, pend_pos_r - CW'(1));
          ram_wdata = val_t'(ram_rdata);
        end
        if (!issue && !pend_r) begin
          occ_nxt   = occ_r - CW'(1);
          state_nxt = (occ_r == CW'(1)) ? S_FINISH : S_RD_FRONT;
        end
      end

      S_RD_FRONT: state_nxt = S_RD_BACK;

      S_RD_BACK: begin
        front_nxt = val_t'(ram_rdata);
        state_nxt = S_RD_LAST;
      end

      S_RD_LAST: begin
        back_nxt  = val_t'(ram_rdata);
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_data_nxt             = out_data_r;
    if (out_load) begin
      out_data_nxt.pad         = '0;
      out_data_nxt.status      = status_r;
      out_data_nxt.found       = found_r;
      out_data_nxt.front_value = is_empty ? '0 : DATA_W'(front_r);
      out_data_nxt.back_value  = is_empty ? '0 : DATA_W'(back_r);
      out_data_nxt.entry_count = COUNT_W'(occ_r);
      out_data_nxt.is_empty    = is_empty;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    pend_pos_r <= pend_pos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- assertions ----
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while one is in work");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found) |-> (out_data_r.status == ST_OK))
    else $error("match reported with a failing status");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (status_r == ST_FULL)) |-> is_full)
    else $error("push dropped while space remained");

endmodule
`default_nettype wire

// ===== hdl/bdb_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bdb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bdb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque/bag unit. A short stimulus table
// covers the empty, full, not-found and unused-opcode cases and the value
// extremes. A long random run follows, biased in phases towards filling or
// draining the store. Every accepted input word runs through a queue-based
// predictor, and every result word is checked field by field. The sender
// runs in bursts and the receiver stalls in patterns of its own.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdb_pkg::*;

  localparam int STORE_DEPTH    = DEPTH_DEF;
  localparam int RANDOM_WORDS   = 1750;
  localparam int WATCHDOG_LIMIT = 5000;
  // longest op is a remove with shift and re-read
  localparam int DRAIN_CYCLES   = 40;

  // opcodes the unit leaves alone
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // opcode [2:0], value [34:3], zero pad [39:35]
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // status [1:0], found [2], front_value [34:3], back_value [66:35],
  // entry_count [71:67], is_empty [72], zero pad [79:73]
  logic [OUT_TDATA_W-1:0] out_tdata;

  bounded_deque_bag_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mirror of the store, front at index 0
  logic [DATA_W-1:0] held_values[$];
  // result words still owed by the unit, oldest first
  out_word_t         owed_results[$];
  int                fail_count  = 0;
  int                idle_cycles = 0;
  int                burst_left  = 0;
  int                rx_mode     = 0;
  int                rx_left     = 0;

  typedef struct {
    logic [2:0]        op;
    logic [DATA_W-1:0] value;
    int                reps;
    bit                typed;   // want holds the result read off by hand
    out_word_t         want;
  } stim_row_t;

  stim_row_t         stim_table[$];
  logic [DATA_W-1:0] value_pool[8];

  function automatic void add_row(logic [2:0] op, logic [DATA_W-1:0] value, int reps,
                                  bit typed, status_t st = ST_OK, bit fnd = 1'b0,
                                  logic [DATA_W-1:0] front = '0,
                                  logic [DATA_W-1:0] back = '0, int cnt = 0);
    stim_row_t row;
    row.op                = op;
    row.value             = value;
    row.reps              = reps;
    row.typed             = typed;
    row.want              = '0;
    row.want.status       = st;
    row.want.found        = fnd;
    row.want.front_value  = front;
    row.want.back_value   = back;
    row.want.entry_count  = cnt[COUNT_W-1:0];
    row.want.is_empty     = (cnt == 0);
    stim_table.push_back(row);
  endfunction

  // Applies one operation to the mirror and returns the result word it owes.
  function automatic out_word_t apply_deque_op(logic [2:0] op, logic [DATA_W-1:0] v);
    out_word_t r;
    int        hit;
    r   = '0;
    hit = -1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held_values.size() >= STORE_DEPTH) begin
          r.status = ST_FULL;               // push dropped
        end else if (op == OP_PUSH_FRONT) begin
          held_values.push_front(v);
        end else begin
          held_values.push_back(v);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held_values.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          void'(held_values.pop_front());
        end else begin
          void'(held_values.pop_back());
        end
      end
      OP_CONTAINS, OP_REMOVE: begin
        if (held_values.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first match counted from the front
          foreach (held_values[i]) begin
            if (hit < 0 && held_values[i] == v) hit = i;
          end
          if (hit >= 0) begin
            r.found = 1'b1;
            if (op == OP_REMOVE) held_values.delete(hit);
          end else if (op == OP_REMOVE) begin
            r.status = ST_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
    if (held_values.size() != 0) begin
      r.front_value = held_values[0];
      r.back_value  = held_values[held_values.size() - 1];
    end
    r.entry_count = COUNT_W'(held_values.size());
    r.is_empty    = (held_values.size() == 0);
    return r;
  endfunction

  // Searches mostly take a stored value; else half pool values, so duplicates
  // build up, then extremes and fully random words so every value bit toggles.
  function automatic logic [DATA_W-1:0] pick_value(bit from_store);
    int pick;
    pick = $urandom_range(0, 99);
    if (from_store && held_values.size() != 0 && pick < 60)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 50) return value_pool[$urandom_range(0, 7)];
    if (pick < 65) begin
      case ($urandom_range(0, 4))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h0000_0001;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Offers one word, waits for the handshake, predicts, then paces the bursts.
  task automatic send_word(logic [2:0] op, logic [DATA_W-1:0] v, bit typed,
                           out_word_t want);
    in_word_t  w;
    out_word_t predicted;
    w        = '0;
    w.opcode = op;
    w.value  = v;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    predicted = apply_deque_op(op, v);
    owed_results.push_back(typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Receiver: switches between stall patterns at random intervals.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 1);
      2:       out_tready <= ($urandom_range(0, 7) == 0);   // long stalls
      default: out_tready <= rx_left[2];                   // follows bit 2 of the pattern counter
    endcase
  end

  // Result checker: every accepted word against the oldest owed result.
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (owed_results.size() == 0) begin
        $error("result word with nothing owed: %h", out_tdata);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          fail_count++;
        end
        if (got.front_value !== want.front_value) begin
          $error("front_value: expected %h, got %h", want.front_value, got.front_value);
          fail_count++;
        end
        if (got.back_value !== want.back_value) begin
          $error("back_value: expected %h, got %h", want.back_value, got.back_value);
          fail_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          fail_count++;
        end
        if (got.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         push_pct;
    int         phase_left;
    int         pick;
    logic [2:0] op;
    bit         search;

    push_pct   = 50;
    phase_left = 0;
    foreach (value_pool[i]) value_pool[i] = (i < 3) ? $urandom_range(0, 9) : $urandom;

    // Directed table. Empty store first, then the extremes, a fill to the
    // brim with duplicates, full pushes, removes at front and middle, drain.
    add_row(OP_POP_FRONT,  '0,           1,  1, ST_EMPTY);
    add_row(OP_POP_BACK,   '0,           1,  1, ST_EMPTY);
    add_row(OP_CONTAINS,   '0,           1,  1, ST_EMPTY);
    add_row(OP_REMOVE,     '0,           1,  1, ST_EMPTY);
    add_row(OP_SPARE_6,    32'hFFFF_FFFF, 1, 1, ST_OK);
    add_row(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1, ST_OK, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    add_row(OP_PUSH_BACK,  32'h8000_0000, 1, 1, ST_OK, 0, 32'h7FFF_FFFF, 32'h8000_0000, 2);
    add_row(OP_CONTAINS,   32'h8000_0000, 1, 1, ST_OK, 1, 32'h7FFF_FFFF, 32'h8000_0000, 2);
    add_row(OP_CONTAINS,   '0,           1,  1, ST_OK, 0, 32'h7FFF_FFFF, 32'h8000_0000, 2);
    add_row(OP_REMOVE,     '0,           1,  1, ST_NOT_FOUND, 0,
            32'h7FFF_FFFF, 32'h8000_0000, 2);
    add_row(OP_REMOVE,     32'h7FFF_FFFF, 1, 1, ST_OK, 1, 32'h8000_0000, 32'h8000_0000, 1);
    add_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 15, 0);
    add_row(OP_PUSH_FRONT, 32'h1234_5678, 1, 1, ST_FULL, 0,
            32'h8000_0000, 32'hFFFF_FFFF, STORE_DEPTH);
    add_row(OP_PUSH_BACK,  '0,           1,  1, ST_FULL, 0,
            32'h8000_0000, 32'hFFFF_FFFF, STORE_DEPTH);
    add_row(OP_SPARE_7,    32'h5555_AAAA, 1, 1, ST_OK, 0,
            32'h8000_0000, 32'hFFFF_FFFF, STORE_DEPTH);
    add_row(OP_CONTAINS,   32'hFFFF_FFFF, 1, 1, ST_OK, 1,
            32'h8000_0000, 32'hFFFF_FFFF, STORE_DEPTH);
    add_row(OP_REMOVE,     32'hFFFF_FFFF, 1, 1, ST_OK, 1,
            32'h8000_0000, 32'hFFFF_FFFF, STORE_DEPTH - 1);
    add_row(OP_REMOVE,     32'h8000_0000, 1, 1, ST_OK, 1,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, STORE_DEPTH - 2);
    add_row(OP_PUSH_FRONT, '0,           1,  0);
    add_row(OP_POP_BACK,   '0,           1,  0);
    add_row(OP_POP_FRONT,  '0,           14, 0);
    add_row(OP_POP_FRONT,  '0,           1,  1, ST_EMPTY);

    // synchronous reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[r]) begin
      repeat (stim_table[r].reps)
        send_word(stim_table[r].op, stim_table[r].value, stim_table[r].typed,
                  stim_table[r].want);
    end

    // Random part: phases lean towards filling or draining so the store
    // spends time both near full and near empty.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 15;
          1:       push_pct = 35;
          2:       push_pct = 50;
          3:       push_pct = 65;
          default: push_pct = 85;
        endcase
        phase_left = $urandom_range(30, 90);
      end
      phase_left--;
      pick   = $urandom_range(0, 99);
      search = 1'b0;
      if (pick < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        else if (pick < 65) op = OP_CONTAINS;
        else if (pick < 95) op = OP_REMOVE;
        else                op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        search = (op == OP_CONTAINS) || (op == OP_REMOVE);
      end
      send_word(op, pick_value(search), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    // let any stray word show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
